// ===== rtl/lfpl_pkg.sv =====
// Package for the linked free page list: item types, mode codes and status codes.
// Used by the top level linked_free_page_list_core. No dependencies.
package lfpl_pkg;

	localparam int PAGE_W  = 12;
	localparam int COUNT_W = 13;
	localparam int MODE_W  = 2;
	localparam int STAT_W  = 2;

	localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GET  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FREE = 2'd2;

	localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_SHORT = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [PAGE_W-1:0]  page;
		logic [COUNT_W-1:0] count;
	} req_t;

	typedef struct packed {
		logic [PAGE_W-1:0]  chain_head;
		logic [STAT_W-1:0]  status;
		logic [COUNT_W-1:0] pages_free;
	} rsp_t;

endpackage

// ===== rtl/lfpl_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies; contents are undefined until written.
module lfpl_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/linked_free_page_list_core.sv =====
// Top level of the linked free page list allocator.
// Depends on lfpl_pkg (types, codes) and lfpl_ram (the next-link memory).
//
// Usage:
// The request channel (req_valid, req_stall, req) carries one item with a mode,
// a page and a count. Mode add links a contiguous run of pages onto the tail of
// the free list, mode get detaches the first count pages as a chain and returns
// its head, and mode free links a returned chain after the tail and walks it to
// find the new tail and the number of pages that came back.
// The response channel (rsp_valid, rsp_stall, rsp) returns exactly one item per
// request: the chain head, a status code and the free page count after the step.
// Flow: the block works on one item at a time. Its work is paced by the single
// next-link memory: one link is written or followed per cycle. The response sits
// in an output register, so a new request is taken while an earlier response is
// still stalled; the block only waits at the end of its work if that register is
// still full.
// Reset clears the list to empty and drops any pending response. The link
// memory is not cleared; every link is written before the list can reach it.
module linked_free_page_list_core #(
	parameter int NUM_PAGES = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  lfpl_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output lfpl_pkg::rsp_t   rsp
);

	// Page index width and link width; a link of NUM_PAGES or more ends a chain.
	localparam int AW = $clog2(NUM_PAGES);
	localparam int LW = AW + 1;
	localparam logic [LW-1:0] LINK_END = LW'(NUM_PAGES);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_CHECK     = 4'd1;
	localparam logic [3:0] S_ADD       = 4'd2;
	localparam logic [3:0] S_ADD_TAIL  = 4'd3;
	localparam logic [3:0] S_GET       = 4'd4;
	localparam logic [3:0] S_FREE_LINK = 4'd5;
	localparam logic [3:0] S_FREE_READ = 4'd6;
	localparam logic [3:0] S_FREE_WALK = 4'd7;
	localparam logic [3:0] S_DONE      = 4'd8;

	logic [3:0]    state_q;
	lfpl_pkg::req_t item_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [LW-1:0] total_q;
	logic [AW-1:0] itr_q;
	logic [AW-1:0] last_q;
	logic [LW-1:0] n_q;
	logic [lfpl_pkg::PAGE_W-1:0] res_head_q;
	logic [lfpl_pkg::STAT_W-1:0] res_status_q;
	lfpl_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;

	// Link memory ports.
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [LW-1:0] wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [LW-1:0] rd_data;

	logic          req_take;
	logic          rsp_room;
	logic          link_end;
	logic [AW-1:0] page_idx;
	logic          get_more;
	logic          free_more;
	logic [LW-1:0] total_less;

	// Saturating add onto the free count.
	function automatic logic [LW-1:0] sat_total(input logic [LW:0] sum);
		logic [LW-1:0] res;
		if (sum > (LW+1)'(NUM_PAGES)) begin
			res = LINK_END;
		end else begin
			res = LW'(sum);
		end
		return res;
	endfunction

	assign req_stall = (state_q != S_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign rsp_room  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The registered read data is always the link of itr_q while walking.
	assign link_end   = (rd_data >= LINK_END);
	assign page_idx   = AW'(item_q.page);
	assign get_more   = (32'(n_q) < 32'(item_q.count));
	assign free_more  = (32'(n_q) < 32'(NUM_PAGES)) && !link_end;
	assign total_less = total_q - LW'(item_q.count);

	// Read port: the head on entry to get, the chain head on entry to free, and
	// the fetched link itself while a walk goes on.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = itr_q;
		unique case (state_q)
			S_CHECK: begin
				rd_en   = (item_q.mode == lfpl_pkg::MODE_GET);
				rd_addr = head_q;
			end
			S_FREE_READ: begin
				rd_en   = 1'b1;
				rd_addr = page_idx;
			end
			S_GET: begin
				rd_en   = get_more && !link_end;
				rd_addr = AW'(rd_data);
			end
			S_FREE_WALK: begin
				rd_en   = free_more;
				rd_addr = AW'(rd_data);
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = itr_q;
			end
		endcase
	end

	// Write port: run links, the old tail's link, and the end mark of a chain.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = itr_q;
		wr_data = LINK_END;
		unique case (state_q)
			S_ADD: begin
				wr_en   = 1'b1;
				wr_addr = itr_q;
				wr_data = (itr_q == last_q) ? LINK_END : LW'(itr_q) + LW'(1);
			end
			S_ADD_TAIL, S_FREE_LINK: begin
				wr_en   = (total_q != '0);
				wr_addr = tail_q;
				wr_data = LW'(page_idx);
			end
			S_GET: begin
				wr_en   = !(get_more && !link_end);
				wr_addr = itr_q;
				wr_data = LINK_END;
			end
			default: begin
				wr_en   = 1'b0;
				wr_addr = itr_q;
				wr_data = LINK_END;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			item_q       <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			total_q      <= '0;
			itr_q        <= '0;
			last_q       <= '0;
			n_q          <= '0;
			res_head_q   <= '0;
			res_status_q <= lfpl_pkg::STATUS_OK;
			rsp_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			// In the done state the response register is refilled below instead.
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_take) begin
						item_q       <= req;
						res_head_q   <= '0;
						res_status_q <= lfpl_pkg::STATUS_OK;
						state_q      <= S_CHECK;
					end
				end
				S_CHECK: begin
					priority if (item_q.mode == lfpl_pkg::MODE_ADD) begin
						if (item_q.count == '0) begin
							res_status_q <= lfpl_pkg::STATUS_SHORT;
							state_q      <= S_DONE;
						end else if (32'(item_q.page) + 32'(item_q.count) >
								32'(NUM_PAGES)) begin
							res_status_q <= lfpl_pkg::STATUS_RANGE;
							state_q      <= S_DONE;
						end else begin
							itr_q   <= page_idx;
							last_q  <= AW'(32'(item_q.page) + 32'(item_q.count) - 32'd1);
							state_q <= S_ADD;
						end
					end else if (item_q.mode == lfpl_pkg::MODE_GET) begin
						if (item_q.count == '0 || 32'(item_q.count) > 32'(total_q)) begin
							res_status_q <= lfpl_pkg::STATUS_SHORT;
							state_q      <= S_DONE;
						end else begin
							itr_q      <= head_q;
							n_q        <= LW'(1);
							res_head_q <= lfpl_pkg::PAGE_W'(head_q);
							state_q    <= S_GET;
						end
					end else if (item_q.mode == lfpl_pkg::MODE_FREE) begin
						if (32'(item_q.page) >= 32'(NUM_PAGES)) begin
							res_status_q <= lfpl_pkg::STATUS_RANGE;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_FREE_LINK;
						end
					end else begin
						// The unused mode changes nothing and answers ok.
						state_q <= S_DONE;
					end
				end
				S_ADD: begin
					if (itr_q == last_q) begin
						if (total_q == '0) begin
							head_q  <= page_idx;
							tail_q  <= last_q;
							total_q <= sat_total((LW+1)'(total_q) + (LW+1)'(item_q.count));
							state_q <= S_DONE;
						end else begin
							state_q <= S_ADD_TAIL;
						end
					end else begin
						itr_q <= itr_q + AW'(1);
					end
				end
				S_ADD_TAIL: begin
					tail_q  <= last_q;
					total_q <= sat_total((LW+1)'(total_q) + (LW+1)'(item_q.count));
					state_q <= S_DONE;
				end
				S_GET: begin
					if (get_more && !link_end) begin
						itr_q <= AW'(rd_data);
						n_q   <= n_q + LW'(1);
					end else begin
						// Either the chain is complete or the list ended early.
						if (get_more || total_less == '0 || link_end) begin
							total_q <= '0;
							head_q  <= '0;
							tail_q  <= '0;
						end else begin
							total_q <= total_less;
							head_q  <= AW'(rd_data);
						end
						state_q <= S_DONE;
					end
				end
				S_FREE_LINK: begin
					if (total_q == '0) begin
						head_q <= page_idx;
					end
					state_q <= S_FREE_READ;
				end
				S_FREE_READ: begin
					itr_q   <= page_idx;
					n_q     <= LW'(1);
					state_q <= S_FREE_WALK;
				end
				S_FREE_WALK: begin
					if (free_more) begin
						itr_q <= AW'(rd_data);
						n_q   <= n_q + LW'(1);
					end else begin
						tail_q  <= itr_q;
						total_q <= sat_total((LW+1)'(total_q) + (LW+1)'(n_q));
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_room) begin
						rsp_q.chain_head <= res_head_q;
						rsp_q.status     <= res_status_q;
						rsp_q.pages_free <= lfpl_pkg::COUNT_W'(total_q);
						rsp_valid_q      <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	lfpl_ram #(
		.WIDTH(LW),
		.DEPTH(NUM_PAGES)
	) u_link_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

endmodule
